### design/pms_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pms_pkg
// Shared widths, constants and helpers of the miter polyline stroker.
// -----------------------------------------------------------------------------
package pms_pkg;

    localparam int CoordW   = 32;
    localparam int HwW      = 24;
    localparam int MulAW    = 35;
    localparam int MulBW    = 31;
    localparam int ProdW    = MulAW + MulBW;
    localparam int OffW     = 37;
    localparam int SumW     = 38;

    localparam logic [HwW-1:0]   HwReset       = 24'd65536;
    localparam logic signed [63:0] StraightLim = 64'sd17592186044416;  // 2^44
    localparam logic [32:0]      TLimit        = 33'h1_FFFF_FFFF;

    // Clamp a wide signed sum to a 32-bit signed word.
    function automatic logic [CoordW-1:0] f_sat32(input logic signed [SumW-1:0] v);
        logic signed [SumW-1:0] hi;
        logic signed [SumW-1:0] lo;
        hi = SumW'(64'sd2147483647);
        lo = -SumW'(64'sd2147483648);
        if (v > hi) begin
            return 32'h7FFF_FFFF;
        end else if (v < lo) begin
            return 32'h8000_0000;
        end
        return v[CoordW-1:0];
    endfunction

    // Magnitude of a Q2.30 unit component (at most 2^30).
    function automatic logic [MulBW-1:0] f_abs_u(input logic signed [31:0] u);
        logic signed [31:0] n;
        n = -u;
        return u[31] ? n[MulBW-1:0] : u[MulBW-1:0];
    endfunction

endpackage

### design/pms_ifs.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pms interfaces
// Point, vertex and configuration channels with valid/ready handshakes.
// -----------------------------------------------------------------------------
interface pms_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               final_point;
    modport source (output valid, point_x, point_y, final_point, input ready);
    modport sink   (input valid, point_x, point_y, final_point, output ready);
endinterface

interface pms_vertex_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_x;
    logic signed [31:0] left_y;
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic               end_of_outline;
    modport source (output valid, left_x, left_y, right_x, right_y, end_of_outline,
                    input ready);
    modport sink   (input valid, left_x, left_y, right_x, right_y, end_of_outline,
                    output ready);
endinterface

interface pms_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] half_width;
    modport source (output valid, half_width, input ready);
    modport sink   (input valid, half_width, output ready);
endinterface

### design/polyline_miter_stroker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// polyline_miter_stroker
// Miter-join stroker: one left/right outline vertex pair per polyline point.
// -----------------------------------------------------------------------------
// Operation: the first point of a polyline is taken and held, and gives no
// word. Later points present their word after one 32-step square root and two
// (start cap, straight joint) or three (miter) 64-step divisions on a shared
// restoring divider; the end-cap word of a final point follows through the OFA,
// OFB, OFC and EMIT states after the first word is taken.
// Throughput: one point at a time; input ready only while idle. Reset: synchronous,
// active low; clears the point history and sets half width 1.0.
// -----------------------------------------------------------------------------
module polyline_miter_stroker
    import pms_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    pms_cfg_if.sink       i_cfg,
    pms_point_if.sink     i_pt,
    pms_vertex_if.source  o_vtx
);

    typedef enum logic [5:0] {
        ST_IDLE, ST_DIFF, ST_SQX, ST_SQY, ST_SQS, ST_SQRT, ST_DXI, ST_DIVX, ST_DIVY,
        ST_IC1, ST_IC2, ST_IC3, ST_IK1, ST_IK2, ST_IK3, ST_IK4, ST_IK5, ST_IDV,
        ST_DIVR, ST_IT1, ST_IT2, ST_IO1, ST_IO2, ST_IO3, ST_IO4, ST_IO5,
        ST_OFA, ST_OFB, ST_OFC, ST_EMIT, ST_WAIT
    } t_state;

    // Control state
    t_state      r_state;
    logic [1:0]  r_ps;          // points held: 0 idle, 1 one, 2 two or more
    logic        r_second;      // working on the end-cap pair of a final point
    logic        r_ov;
    logic [HwW-1:0] r_hw;

    // Point history and the current point
    logic signed [31:0] r_rx, r_ry, r_px, r_py;
    logic               r_fin;
    logic signed [31:0] r_u1x, r_u1y, r_u2x, r_u2y;

    // Direction of the new segment
    logic [30:0] r_ax, r_ay;
    logic        r_dxneg, r_dyneg;

    // Shared multiplier and accumulator
    logic [ProdW-1:0]   r_prod;
    logic               r_pneg;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_c;

    // Square root unit
    logic [63:0] r_srem, r_sres, r_sbit;

    // Restoring divider
    logic [63:0] r_dnum;
    logic [34:0] r_dden;
    logic [35:0] r_drem;
    logic [5:0]  r_dcnt;

    // Miter scale
    logic        r_rneg;
    logic [34:0] r_rmag;
    logic [32:0] r_tm;
    logic        r_tneg;

    // Offsets and result word
    logic signed [OffW-1:0] r_ox, r_oy;
    logic [31:0] r_lx, r_ly, r_rgx, r_rgy;
    logic        r_eoo;

    // ---------------------------------------------------------------------
    // Multiplier operand select: one product per cycle, used the next cycle.
    // ---------------------------------------------------------------------
    logic [MulAW-1:0] mul_a;
    logic [MulBW-1:0] mul_b;
    logic             mul_neg;
    logic signed [31:0] cvx, cvy;

    // Cap vector: u1 on a straight inner joint, u2 otherwise
    assign cvx = (!r_second && r_ps == 2'd2) ? r_u1x : r_u2x;
    assign cvy = (!r_second && r_ps == 2'd2) ? r_u1y : r_u2y;

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (r_state)
            ST_SQX: begin
                mul_a = MulAW'(r_ax);
                mul_b = r_ax;
            end
            ST_SQY: begin
                mul_a = MulAW'(r_ay);
                mul_b = r_ay;
            end
            ST_IC1: begin
                mul_a   = MulAW'(f_abs_u(r_u1x));
                mul_b   = f_abs_u(r_u2y);
                mul_neg = r_u1x[31] ^ r_u2y[31];
            end
            ST_IC2: begin
                mul_a   = MulAW'(f_abs_u(r_u1y));
                mul_b   = f_abs_u(r_u2x);
                mul_neg = r_u1y[31] ^ r_u2x[31];
            end
            ST_IK1: begin
                mul_a = MulAW'(f_abs_u(r_u1x));
                mul_b = f_abs_u(r_u1x);
            end
            ST_IK2: begin
                mul_a = MulAW'(f_abs_u(r_u1y));
                mul_b = f_abs_u(r_u1y);
            end
            ST_IK3: begin
                mul_a   = MulAW'(f_abs_u(r_u1x));
                mul_b   = f_abs_u(r_u2x);
                mul_neg = r_u1x[31] ^ r_u2x[31];
            end
            ST_IK4: begin
                mul_a   = MulAW'(f_abs_u(r_u1y));
                mul_b   = f_abs_u(r_u2y);
                mul_neg = r_u1y[31] ^ r_u2y[31];
            end
            ST_IT1: begin
                mul_a = r_rmag;
                mul_b = MulBW'(r_hw);
            end
            ST_IO1: begin
                mul_a   = MulAW'(r_hw);
                mul_b   = f_abs_u(r_u2y);
                mul_neg = !r_u2y[31] && (r_u2y != 32'sd0);
            end
            ST_IO2: begin
                mul_a   = MulAW'(r_tm);
                mul_b   = f_abs_u(r_u2x);
                mul_neg = r_tneg ^ r_u2x[31];
            end
            ST_IO3: begin
                mul_a   = MulAW'(r_hw);
                mul_b   = f_abs_u(r_u2x);
                mul_neg = r_u2x[31];
            end
            ST_IO4: begin
                mul_a   = MulAW'(r_tm);
                mul_b   = f_abs_u(r_u2y);
                mul_neg = r_tneg ^ r_u2y[31];
            end
            ST_OFA: begin
                mul_a   = MulAW'(r_hw);
                mul_b   = f_abs_u(cvy);
                mul_neg = !cvy[31] && (cvy != 32'sd0);
            end
            ST_OFB: begin
                mul_a   = MulAW'(r_hw);
                mul_b   = f_abs_u(cvx);
                mul_neg = cvx[31];
            end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                mul_neg = 1'b0;
            end
        endcase
    end

    // Signed product and offset from the product register, rounded to drop the Q30 scale of the unit component
    logic signed [63:0]     sp;
    logic [ProdW-1:0]       rnd_full;
    logic signed [OffW-1:0] off;
    assign sp       = r_pneg ? -$signed(r_prod[63:0]) : $signed(r_prod[63:0]);
    assign rnd_full = (r_prod + (ProdW'(1) << 29)) >> 30;
    assign off      = r_pneg ? -$signed({1'b0, rnd_full[OffW-2:0]})
                             :  $signed({1'b0, rnd_full[OffW-2:0]});

    // Segment difference, magnitude and halving
    logic signed [32:0] dx, dy;
    logic [31:0] adx, ady;
    logic        halve;
    assign dx    = 33'(r_px) - 33'(r_rx);
    assign dy    = 33'(r_py) - 33'(r_ry);
    assign adx   = dx[32] ? 32'(-dx) : dx[31:0];
    assign ady   = dy[32] ? 32'(-dy) : dy[31:0];
    assign halve = adx[31] | ady[31];

    // Square root step
    logic [63:0] sq_trial, sq_rem_n, sq_res_n;
    logic        sq_ge;
    assign sq_trial = r_sres + r_sbit;
    assign sq_ge    = r_srem >= sq_trial;
    assign sq_rem_n = sq_ge ? r_srem - sq_trial : r_srem;
    assign sq_res_n = sq_ge ? (r_sres >> 1) + r_sbit : r_sres >> 1;

    // Divider step: one quotient bit
    logic [35:0] dv_sh, dv_rem_n;
    logic        dv_ge;
    logic [63:0] dv_num_n;
    assign dv_sh    = {r_drem[34:0], r_dnum[63]};
    assign dv_ge    = dv_sh >= {1'b0, r_dden};
    assign dv_rem_n = dv_ge ? dv_sh - {1'b0, r_dden} : dv_sh;
    assign dv_num_n = {r_dnum[62:0], dv_ge};

    // Cross product and miter quotient operands
    logic signed [63:0] c_new, kk, cc;
    logic [63:0] kk_mag;
    logic [63:0] cc_mag;
    assign c_new  = r_acc - sp;
    assign kk     = r_acc >>> 14;
    assign cc     = ((r_c >>> 30) == 64'sd0) ? 64'sd1 : (r_c >>> 30);
    assign kk_mag = kk[63] ? 64'(-kk) : 64'(kk);
    assign cc_mag = cc[63] ? 64'(-cc) : 64'(cc);

    // Miter length t = floor(h*r / 2^16), clamped
    logic [ProdW-1:0] t_full;
    assign t_full = r_rneg ? (r_prod + ProdW'(16'hFFFF)) >> 16 : r_prod >> 16;

    // Vertex sums
    logic signed [SumW-1:0] bx, by;
    assign bx = SumW'(r_second ? r_px : r_rx);
    assign by = SumW'(r_second ? r_py : r_ry);

    // Take nothing while reset is held
    assign i_pt.ready  = i_rst_n && (r_state == ST_IDLE);
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        r_prod <= ProdW'(mul_a) * ProdW'(mul_b);
        r_pneg <= mul_neg;

        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ps     <= 2'd0;
            r_second <= 1'b0;
            r_ov     <= 1'b0;
            r_hw     <= HwReset;
            r_rx     <= '0;
            r_ry     <= '0;
            r_u1x    <= '0;
            r_u1y    <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_hw <= i_cfg.half_width;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_pt.valid) begin
                        r_px  <= i_pt.point_x;
                        r_py  <= i_pt.point_y;
                        r_fin <= i_pt.final_point;
                        if (r_ps == 2'd0) begin
                            // first point: hold it, no word
                            r_rx <= i_pt.point_x;
                            r_ry <= i_pt.point_y;
                            r_ps <= i_pt.final_point ? 2'd0 : 2'd1;
                        end else begin
                            r_state <= ST_DIFF;
                        end
                    end
                end
                ST_DIFF: begin
                    r_dxneg <= dx[32];
                    r_dyneg <= dy[32];
                    r_ax    <= halve ? adx[31:1] : adx[30:0];
                    r_ay    <= halve ? ady[31:1] : ady[30:0];
                    r_state <= ST_SQX;
                end
                ST_SQX: r_state <= ST_SQY;
                ST_SQY: begin
                    r_acc   <= sp;
                    r_state <= ST_SQS;
                end
                ST_SQS: begin
                    r_srem  <= 64'(r_acc + sp);
                    r_sres  <= '0;
                    r_sbit  <= 64'h4000_0000_0000_0000;
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    r_srem <= sq_rem_n;
                    r_sres <= sq_res_n;
                    r_sbit <= r_sbit >> 2;
                    if (r_sbit[0]) begin
                        r_state <= ST_DXI;
                    end
                end
                ST_DXI: begin
                    // divide by the length, at least one
                    r_dden  <= (r_sres == 64'd0) ? 35'd1 : r_sres[34:0];
                    r_dnum  <= {3'b0, r_ax, 30'b0};
                    r_drem  <= '0;
                    r_dcnt  <= '0;
                    r_state <= ST_DIVX;
                end
                ST_DIVX: begin
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd63) begin
                        r_u2x   <= r_dxneg ? -$signed({1'b0, dv_num_n[30:0]})
                                           :  $signed({1'b0, dv_num_n[30:0]});
                        // load the y component next
                        r_dnum  <= {3'b0, r_ay, 30'b0};
                        r_drem  <= '0;
                        r_state <= ST_DIVY;
                    end else begin
                        r_drem <= dv_rem_n;
                        r_dnum <= dv_num_n;
                    end
                end
                ST_DIVY: begin
                    r_drem <= dv_rem_n;
                    r_dnum <= dv_num_n;
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd63) begin
                        r_u2y   <= r_dyneg ? -$signed({1'b0, dv_num_n[30:0]})
                                           :  $signed({1'b0, dv_num_n[30:0]});
                        r_state <= (r_ps == 2'd1) ? ST_OFA : ST_IC1;
                    end
                end
                ST_IC1: r_state <= ST_IC2;
                ST_IC2: begin
                    r_acc   <= sp;
                    r_state <= ST_IC3;
                end
                ST_IC3: begin
                    r_c <= c_new;
                    // nearly straight: plain offset along the first normal
                    if (c_new <= StraightLim && c_new >= -StraightLim) begin
                        r_state <= ST_OFA;
                    end else begin
                        r_state <= ST_IK1;
                    end
                end
                ST_IK1: r_state <= ST_IK2;
                ST_IK2: begin
                    r_acc   <= sp;
                    r_state <= ST_IK3;
                end
                ST_IK3: begin
                    r_acc   <= r_acc + sp;
                    r_state <= ST_IK4;
                end
                ST_IK4: begin
                    r_acc   <= r_acc - sp;
                    r_state <= ST_IK5;
                end
                ST_IK5: begin
                    r_acc   <= r_acc - sp;
                    r_state <= ST_IDV;
                end
                ST_IDV: begin
                    r_rneg  <= kk[63] ^ cc[63];
                    r_dnum  <= kk_mag;
                    r_dden  <= cc_mag[34:0];
                    r_drem  <= '0;
                    r_dcnt  <= '0;
                    r_state <= ST_DIVR;
                end
                ST_DIVR: begin
                    r_drem <= dv_rem_n;
                    r_dnum <= dv_num_n;
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd63) begin
                        r_rmag  <= dv_num_n[34:0];
                        r_state <= ST_IT1;
                    end
                end
                ST_IT1: r_state <= ST_IT2;
                ST_IT2: begin
                    r_tm    <= (t_full > ProdW'(TLimit)) ? TLimit : t_full[32:0];
                    r_tneg  <= r_rneg;
                    r_state <= ST_IO1;
                end
                ST_IO1: r_state <= ST_IO2;
                ST_IO2: begin
                    r_ox    <= off;
                    r_state <= ST_IO3;
                end
                ST_IO3: begin
                    r_ox    <= r_ox + off;
                    r_state <= ST_IO4;
                end
                ST_IO4: begin
                    r_oy    <= off;
                    r_state <= ST_IO5;
                end
                ST_IO5: begin
                    r_oy    <= r_oy + off;
                    r_state <= ST_EMIT;
                end
                ST_OFA: r_state <= ST_OFB;
                ST_OFB: begin
                    r_ox    <= off;
                    r_state <= ST_OFC;
                end
                ST_OFC: begin
                    r_oy    <= off;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    r_lx    <= f_sat32(bx + SumW'(r_ox));
                    r_ly    <= f_sat32(by + SumW'(r_oy));
                    r_rgx   <= f_sat32(bx - SumW'(r_ox));
                    r_rgy   <= f_sat32(by - SumW'(r_oy));
                    r_eoo   <= r_second;
                    r_ov    <= 1'b1;
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (o_vtx.ready) begin
                        r_ov <= 1'b0;
                        if (r_fin && !r_second) begin
                            // final point: follow with the end cap
                            r_second <= 1'b1;
                            r_state  <= ST_OFA;
                        end else begin
                            r_second <= 1'b0;
                            if (r_fin) begin
                                r_ps <= 2'd0;
                            end else begin
                                r_rx  <= r_px;
                                r_ry  <= r_py;
                                r_u1x <= r_u2x;
                                r_u1y <= r_u2y;
                                r_ps  <= 2'd2;
                            end
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_vtx.valid          = r_ov;
    assign o_vtx.left_x         = r_lx;
    assign o_vtx.left_y         = r_ly;
    assign o_vtx.right_x        = r_rgx;
    assign o_vtx.right_y        = r_rgy;
    assign o_vtx.end_of_outline = r_eoo;

endmodule
